[sv/phr_pkg.sv]
// ----------------------------------------------------------------------------
// phr_pkg
// Shared types and constants of the per-channel history ring: field widths,
// command and status codes, default sizes and the sequencer states.
// ----------------------------------------------------------------------------
package phr_pkg;

  // Field widths of the command and result words.
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 8;
  localparam int AGO_W    = 6;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;
  localparam int CFG_W    = 7;

  // Default sizes handed to the top level.
  localparam int CHANNELS_DEF     = 64;
  localparam int DEPTH_MAX_DEF    = 64;
  localparam int SAMPLE_WIDTH_DEF = 64;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [FILL_W-1:0]   fill_t;

  // Command codes; the remaining codes behave like a count query.
  localparam cmd_t CMD_RECORD    = 3'd0;
  localparam cmd_t CMD_COUNT     = 3'd1;
  localparam cmd_t CMD_READ      = 3'd2;
  localparam cmd_t CMD_CLEAR     = 3'd3;
  localparam cmd_t CMD_CLEAR_ALL = 3'd4;

  // Status codes.
  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_BAD_SLOT    = 2'd1;
  localparam status_t ST_AGE_RANGE   = 2'd2;
  localparam status_t ST_SAMPLE_SKIP = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOOKUP,
    SEQ_DONE
  } seq_state_t;

endpackage

[sv/phr_in_if.sv]
// ----------------------------------------------------------------------------
// phr_in_if
// Command channel: valid/ready handshake and one command word.
// ----------------------------------------------------------------------------
interface phr_in_if;
  logic                 valid;
  logic                 ready;
  phr_pkg::cmd_t        command;
  logic [phr_pkg::SLOT_W-1:0] slot;
  logic [phr_pkg::AGO_W-1:0]  ago;
  phr_pkg::word_t       sample_in;
  logic                 sample_valid;

  modport source (
    output valid, command, slot, ago, sample_in, sample_valid,
    input  ready
  );
  modport sink (
    input  valid, command, slot, ago, sample_in, sample_valid,
    output ready
  );
endinterface

[sv/phr_out_if.sv]
// ----------------------------------------------------------------------------
// phr_out_if
// Result channel: valid/ready handshake and one result word.
// ----------------------------------------------------------------------------
interface phr_out_if;
  logic              valid;
  logic              ready;
  phr_pkg::status_t  status;
  phr_pkg::fill_t    fill_count;
  phr_pkg::word_t    read_data;

  modport source (
    output valid, status, fill_count, read_data,
    input  ready
  );
  modport sink (
    input  valid, status, fill_count, read_data,
    output ready
  );
endinterface

[sv/phr_sample_mem.sv]
// ----------------------------------------------------------------------------
// phr_sample_mem
// Sample store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module phr_sample_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/per_channel_history_ring.sv]
// ----------------------------------------------------------------------------
// per_channel_history_ring
// Circular sample history per channel, held in a channel metadata memory
// (head and fill) and a sample memory, served by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one command word (record, count query, read back, clear
//   channel, clear all). out_chan returns exactly one result word for each
//   command, in order. cfg_we/cfg_wdata write the history depth; write it
//   only while no command is in flight. A larger depth empties every ring,
//   a smaller one is ignored.
//   Each command passes through the idle, lookup and done states: the
//   accept edge reads the channel's metadata memory, the end of lookup
//   updates it and reads or writes the sample memory, and the done state
//   loads the output register once that is free. A new command is taken
//   only after the output register is loaded, so commands never overlap;
//   this pacing follows from the registered reads of both memories.
//   Reset (synchronous, rst_n low) sets the depth to 1 and marks every
//   channel empty at once through per-channel valid bits; no clearing pass.
//   If the receiver stalls, the result waits in the output register while
//   one more command is processed; that one then holds with in_chan.ready
//   low until the output register frees.
// ----------------------------------------------------------------------------
module per_channel_history_ring #(
  parameter int CHANNELS     = phr_pkg::CHANNELS_DEF,
  parameter int DEPTH_MAX    = phr_pkg::DEPTH_MAX_DEF,
  parameter int SAMPLE_WIDTH = phr_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [phr_pkg::CFG_W-1:0] cfg_wdata,
  phr_in_if.sink                    in_chan,
  phr_out_if.source                 out_chan
);

  localparam int DEPTH_CAP = (DEPTH_MAX < 127) ? DEPTH_MAX : 127;
  localparam int IDX_W     = (DEPTH_CAP > 1) ? $clog2(DEPTH_CAP) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FILL_W    = phr_pkg::FILL_W;
  localparam int META_W    = IDX_W + FILL_W;
  localparam int CH_N      = 1 << CH_W;

  phr_pkg::seq_state_t state_r, state_nxt;

  logic                  in_acc;
  logic                  in_ready;
  logic                  out_free;

  // Command word held for the whole sequence.
  phr_pkg::cmd_t            cmd_r;
  logic [phr_pkg::SLOT_W-1:0] slot_r;
  logic [phr_pkg::AGO_W-1:0]  ago_r;
  logic [SAMPLE_WIDTH-1:0]  sample_r;
  logic                     svalid_r;

  logic [phr_pkg::CFG_W-1:0] depth_r;
  logic [phr_pkg::CFG_W-1:0] cfg_clamp;
  logic                      cfg_grow;

  logic [META_W-1:0]     meta_mem [0:CH_N-1];
  logic [META_W-1:0]     meta_q;
  logic [CH_N-1:0]       chan_valid_r;

  logic [CH_W-1:0]       ch;
  logic                  slot_ok;
  logic [IDX_W-1:0]      cur_head;
  phr_pkg::fill_t        cur_fill;
  logic [6:0]            head_inc;
  logic [IDX_W-1:0]      next_head;
  phr_pkg::fill_t        next_fill;
  logic [7:0]            rd_diff;
  logic [7:0]            rd_idx8;
  logic [IDX_W-1:0]      rd_idx;
  logic                  age_ok;

  logic                  meta_we;
  logic                  ram_we;
  logic                  ram_re;
  logic                  clr_one;
  logic                  clr_all;
  phr_pkg::status_t      res_status;
  phr_pkg::fill_t        res_fill;
  logic                  res_read;

  phr_pkg::status_t      res_status_r;
  phr_pkg::fill_t        res_fill_r;
  logic                  res_read_r;
  logic [SAMPLE_WIDTH-1:0] ram_q;

  logic                  out_valid_r;
  phr_pkg::status_t      out_status_r;
  phr_pkg::fill_t        out_fill_r;
  phr_pkg::word_t        out_data_r;

  assign in_acc   = in_chan.valid && in_ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // Depth register: clamp the written value, keep it only if it grows.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamp = 7'd1;
    end else if (cfg_wdata > 7'(DEPTH_CAP)) begin
      cfg_clamp = 7'(DEPTH_CAP);
    end else begin
      cfg_clamp = cfg_wdata;
    end
  end

  assign cfg_grow = cfg_we && (cfg_clamp > depth_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= 7'd1;
    end else if (cfg_grow) begin
      depth_r <= cfg_clamp;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phr_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      phr_pkg::SEQ_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = phr_pkg::SEQ_LOOKUP;
        end
      end
      phr_pkg::SEQ_LOOKUP: begin
        state_nxt = phr_pkg::SEQ_DONE;
      end
      phr_pkg::SEQ_DONE: begin
        if (out_free) begin
          state_nxt = phr_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = phr_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign in_chan.ready = in_ready;

  // Capture the command word on accept.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_chan.command;
      slot_r   <= in_chan.slot;
      ago_r    <= in_chan.ago;
      sample_r <= in_chan.sample_in[SAMPLE_WIDTH-1:0];
      svalid_r <= in_chan.sample_valid;
    end
  end

  // Channel metadata memory: read on accept, written back during lookup.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meta_q <= meta_mem[in_chan.slot[CH_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[ch] <= {next_head, next_fill};
    end
  end

  // Valid bits: a channel without one reads as head 0, fill 0.
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all || cfg_grow) begin
      chan_valid_r <= '0;
    end else if (meta_we) begin
      chan_valid_r[ch] <= 1'b1;
    end else if (clr_one) begin
      chan_valid_r[ch] <= 1'b0;
    end
  end

  // Current head and fill of the addressed channel.
  assign ch       = slot_r[CH_W-1:0];
  assign slot_ok  = {1'b0, slot_r} < 9'(CHANNELS);
  assign cur_head = chan_valid_r[ch] ? meta_q[META_W-1:FILL_W] : '0;
  assign cur_fill = chan_valid_r[ch] ? meta_q[FILL_W-1:0] : '0;

  // Head advance with wrap at the depth, and saturating fill.
  assign head_inc  = 7'(cur_head) + 7'd1;
  assign next_head = (head_inc == depth_r) ? '0 : head_inc[IDX_W-1:0];
  assign next_fill = (cur_fill < depth_r) ? cur_fill + 7'd1 : cur_fill;

  // Read position: head minus one minus age, wrapped once by the depth.
  assign rd_diff = 8'(cur_head) - 8'(ago_r) - 8'd1;
  assign rd_idx8 = rd_diff[7] ? rd_diff + 8'(depth_r) : rd_diff;
  assign rd_idx  = rd_idx8[IDX_W-1:0];
  assign age_ok  = {1'b0, ago_r} < cur_fill;

  // Command decode during the lookup cycle.
  always_comb begin
    meta_we    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    clr_one    = 1'b0;
    clr_all    = 1'b0;
    res_status = phr_pkg::ST_OK;
    res_fill   = cur_fill;
    res_read   = 1'b0;
    if (state_r == phr_pkg::SEQ_LOOKUP) begin
      if (cmd_r == phr_pkg::CMD_CLEAR_ALL) begin
        clr_all  = 1'b1;
        res_fill = '0;
      end else if (!slot_ok) begin
        res_status = phr_pkg::ST_BAD_SLOT;
        res_fill   = '0;
      end else begin
        case (cmd_r)
          phr_pkg::CMD_RECORD: begin
            if (!svalid_r) begin
              res_status = phr_pkg::ST_SAMPLE_SKIP;
            end else begin
              ram_we   = 1'b1;
              meta_we  = 1'b1;
              res_fill = next_fill;
            end
          end
          phr_pkg::CMD_READ: begin
            if (!age_ok) begin
              res_status = phr_pkg::ST_AGE_RANGE;
            end else begin
              ram_re   = 1'b1;
              res_read = 1'b1;
            end
          end
          phr_pkg::CMD_CLEAR: begin
            clr_one  = 1'b1;
            res_fill = '0;
          end
          default: begin
            res_fill = cur_fill;
          end
        endcase
      end
    end
  end

  // Result of the lookup, waiting for the sample read to return.
  always_ff @(posedge clk) begin
    if (state_r == phr_pkg::SEQ_LOOKUP) begin
      res_status_r <= res_status;
      res_fill_r   <= res_fill;
      res_read_r   <= res_read;
    end
  end

  phr_sample_mem #(
    .ADDR_W (CH_W + IDX_W),
    .DATA_W (SAMPLE_WIDTH)
  ) u_sample_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({ch, cur_head}),
    .wdata (sample_r),
    .re    (ram_re),
    .raddr ({ch, rd_idx}),
    .rdata (ram_q)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == phr_pkg::SEQ_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == phr_pkg::SEQ_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_fill_r   <= res_fill_r;
      out_data_r   <= res_read_r ? phr_pkg::word_t'(ram_q) : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.fill_count = out_fill_r;
  assign out_chan.read_data  = out_data_r;

  // An accepted word always starts a lookup.
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == phr_pkg::SEQ_LOOKUP)
    else $error("accepted command did not start a lookup");

  // A written fill count never exceeds the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    meta_we |-> (next_fill <= depth_r))
    else $error("fill count above depth");

  // The sample store is only read inside the filled part of the ring.
  a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (({1'b0, ago_r} < cur_fill) && (rd_idx8 < 8'(depth_r))))
    else $error("sample read outside filled entries");

  // Growing the depth empties every channel.
  a_grow_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_grow |=> (chan_valid_r == '0))
    else $error("depth growth left a channel filled");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for per_channel_history_ring. Commands go in over the
// command channel with random sender gaps, and results come back with random
// receiver stalls. A cycle-free model of the per-channel rings predicts each
// result word in order. The history depth is raised in steps from 1 to the
// largest size, with writes of zero, smaller values and an out-of-range
// value among them. A directed opening covers the corner cases, and random
// traffic on a few busy channels then fills and wraps the rings.
// ----------------------------------------------------------------------------
module testbench;
  import phr_pkg::*;

  localparam int CHANNELS    = CHANNELS_DEF;
  localparam int DEPTH_MAX   = DEPTH_MAX_DEF;
  localparam int AGO_MAX     = 2**AGO_W - 1;
  localparam int SLOT_MAX    = 2**SLOT_W - 1;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE      = 6;

  // Command codes with no function of their own; they answer like a count query.
  localparam cmd_t CMD_SPARE_LO = 3'd5;
  localparam cmd_t CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t status;
    fill_t   fill;
    word_t   data;
  } answer_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;

  phr_in_if  cmd_bus ();
  phr_out_if res_bus ();

  per_channel_history_ring u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (cmd_bus),
    .out_chan  (res_bus)
  );

  // Shadow copy of the rings, heads, fill levels and the depth.
  word_t            ring_mem  [CHANNELS][DEPTH_MAX];
  logic [AGO_W-1:0] ring_head [CHANNELS];
  fill_t            ring_fill [CHANNELS];
  logic [CFG_W-1:0] ring_depth;

  answer_t pending_answers[$];
  answer_t head_answer;
  int      mismatch_cnt;
  int      quiet_cycles;
  int      stall_left;
  bit      idle_on;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void empty_rings();
    foreach (ring_head[i]) begin
      ring_head[i] = '0;
      ring_fill[i] = '0;
    end
  endfunction

  // Applies one command to the shadow rings and returns the answer it earns.
  function automatic answer_t ring_update(cmd_t c, logic [SLOT_W-1:0] s,
                                          logic [AGO_W-1:0] a, word_t d, logic v);
    answer_t r;
    int      ch;
    int      idx;
    r = '0;
    if (c == CMD_CLEAR_ALL) begin
      empty_rings();
      return r;
    end
    if (s >= CHANNELS) begin
      r.status = ST_BAD_SLOT;
      return r;
    end
    ch = int'(s);
    case (c)
      CMD_RECORD: begin
        if (!v) begin
          r.status = ST_SAMPLE_SKIP;
        end else begin
          idx = int'(ring_head[ch]) % int'(ring_depth);
          ring_mem[ch][idx] = d;
          ring_head[ch] = AGO_W'((idx + 1) % int'(ring_depth));
          if (ring_fill[ch] < ring_depth) ring_fill[ch]++;
        end
      end
      CMD_READ: begin
        if (a >= ring_fill[ch]) begin
          r.status = ST_AGE_RANGE;
        end else begin
          idx = (int'(ring_head[ch]) + int'(ring_depth) - 1 - int'(a)) % int'(ring_depth);
          r.data = ring_mem[ch][idx];
        end
      end
      CMD_CLEAR: begin
        ring_head[ch] = '0;
        ring_fill[ch] = '0;
      end
      default: ;
    endcase
    r.fill = ring_fill[ch];
    return r;
  endfunction

  // Receiver: ready drops in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      res_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      res_bus.ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // Each accepted result word is compared with the oldest predicted answer.
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_answers.size() == 0) begin
        $error("result word with no answer pending");
        mismatch_cnt++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (res_bus.status !== head_answer.status) begin
          $error("status: expected %0d, got %0d", head_answer.status, res_bus.status);
          mismatch_cnt++;
        end
        if (res_bus.fill_count !== head_answer.fill) begin
          $error("fill_count: expected %0d, got %0d", head_answer.fill, res_bus.fill_count);
          mismatch_cnt++;
        end
        if (res_bus.read_data !== head_answer.data) begin
          $error("read_data: expected %h, got %h", head_answer.data, res_bus.read_data);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run once no word has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no word moved for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Sends one command word, with an optional gap first, and predicts its answer.
  task automatic send_word(cmd_t c, logic [SLOT_W-1:0] s, logic [AGO_W-1:0] a,
                           word_t d, logic v);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.command      <= c;
    cmd_bus.slot         <= s;
    cmd_bus.ago          <= a;
    cmd_bus.sample_in    <= d;
    cmd_bus.sample_valid <= v;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    pending_answers.push_back(ring_update(c, s, a, d, v));
  endtask

  // Holds the sender until every predicted answer has come back.
  task automatic wait_until_drained();
    cmd_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes the history depth while the block is idle and tracks its effect.
  task automatic write_depth(logic [CFG_W-1:0] value);
    int eff;
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    eff = int'(value);
    if (eff < 1) eff = 1;
    if (eff > DEPTH_MAX) eff = DEPTH_MAX;
    if (eff > ring_depth) begin
      ring_depth = CFG_W'(eff);
      empty_rings();
    end
    @(posedge clk);
  endtask

  // Random commands, mostly aimed at a few busy channels so the rings fill up.
  task automatic run_traffic(int n, int hot_count, int clear_permille);
    cmd_t             c;
    logic [SLOT_W-1:0] s;
    logic [AGO_W-1:0]  a;
    int               pick;
    int               fill;
    int               hot_base;
    hot_base = $urandom_range(0, CHANNELS - hot_count);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) s = SLOT_W'(hot_base + $urandom_range(0, hot_count - 1));
      else if (pick < 90) s = SLOT_W'($urandom_range(0, CHANNELS - 1));
      else s = SLOT_W'($urandom_range(CHANNELS, SLOT_MAX));

      if ($urandom_range(0, 999) < clear_permille) begin
        c = ($urandom_range(0, 4) == 0) ? CMD_CLEAR_ALL : CMD_CLEAR;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) c = CMD_RECORD;
        else if (pick < 60) c = CMD_COUNT;
        else if (pick < 95) c = CMD_READ;
        else c = cmd_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end

      // Ages mostly fall inside the fill, with the oldest entry and the
      // first out-of-range age picked on purpose.
      fill = (s < CHANNELS) ? int'(ring_fill[s]) : 0;
      pick = $urandom_range(0, 99);
      if (pick < 70 && fill > 0) a = AGO_W'($urandom_range(0, fill - 1));
      else if (pick < 78) a = AGO_W'((fill == 0) ? 0 : fill - 1);
      else if (pick < 86) a = AGO_W'((fill > AGO_MAX) ? AGO_MAX : fill);
      else a = AGO_W'($urandom_range(0, AGO_MAX));

      if ($urandom_range(0, 199) == 0) wait_until_drained();
      send_word(c, s, a, {$urandom, $urandom}, $urandom_range(0, 9) != 0);
    end
  endtask

  // Corner cases at the reset depth of one entry.
  task automatic test_directed();
    send_word(CMD_COUNT, 0, 0, '0, 1'b1);
    send_word(CMD_READ, 0, 0, '0, 1'b1);
    send_word(CMD_RECORD, 0, AGO_W'(AGO_MAX), '1, 1'b0);
    send_word(CMD_RECORD, SLOT_W'(CHANNELS - 1), 0, '1, 1'b1);
    send_word(CMD_RECORD, SLOT_W'(CHANNELS - 1), 0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1);
    send_word(CMD_READ, SLOT_W'(CHANNELS - 1), 0, '0, 1'b1);
    send_word(CMD_READ, SLOT_W'(CHANNELS - 1), AGO_W'(AGO_MAX), '0, 1'b1);
    send_word(CMD_RECORD, SLOT_W'(CHANNELS), 0, '1, 1'b1);
    // A bad channel wins over an invalid sample.
    send_word(CMD_RECORD, SLOT_W'(SLOT_MAX), 0, '1, 1'b0);
    send_word(CMD_READ, 8'h80, 0, '0, 1'b1);
    send_word(CMD_CLEAR, 8'hC8, 0, '0, 1'b1);
    for (int k = CMD_SPARE_LO; k <= CMD_SPARE_HI; k++) begin
      send_word(cmd_t'(k), SLOT_W'(CHANNELS - 1), AGO_W'(AGO_MAX), '1, 1'b1);
    end
    send_word(CMD_SPARE_HI, SLOT_W'(SLOT_MAX), 0, '0, 1'b0);
    send_word(CMD_CLEAR, SLOT_W'(CHANNELS - 1), 0, '0, 1'b1);
    send_word(CMD_RECORD, SLOT_W'(CHANNELS - 1), 0, '0, 1'b1);
    send_word(CMD_RECORD, 1, 0, 64'h8000_0000_0000_0001, 1'b1);
    // Clear all ignores the slot, even a bad one.
    send_word(CMD_CLEAR_ALL, SLOT_W'(SLOT_MAX), AGO_W'(AGO_MAX), '1, 1'b1);
    send_word(CMD_COUNT, 1, 0, '0, 1'b1);
    send_word(CMD_COUNT, SLOT_W'(CHANNELS - 1), 0, '0, 1'b1);
    send_word(CMD_RECORD, 0, 0, 64'h0123_4567_89AB_CDEF, 1'b1);
    send_word(CMD_READ, 0, 0, '0, 1'b1);
  endtask

  // Random traffic at depth one; writes of zero and one leave it unchanged.
  task automatic test_depth_one();
    run_traffic(50, 4, 40);
    write_depth(0);
    write_depth(1);
    run_traffic(30, 4, 40);
  endtask

  // Depth rises step by step; a smaller write must not empty the rings.
  task automatic test_depth_growth();
    write_depth(5);
    send_word(CMD_COUNT, 1, 0, '0, 1'b1);
    run_traffic(130, 3, 30);
    write_depth(3);
    idle_on = 1'b0;
    run_traffic(120, 3, 30);
    idle_on = 1'b1;
    write_depth(23);
    run_traffic(140, 2, 10);
  endtask

  // Full depth: an out-of-range write clamps, later writes are ignored, and
  // one busy channel wraps its ring several times.
  task automatic test_full_depth();
    write_depth(127);
    write_depth(CFG_W'(DEPTH_MAX));
    write_depth(100);
    run_traffic(260, 1, 5);
    idle_on = 1'b0;
    run_traffic(120, 1, 5);
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.command      = CMD_COUNT;
    cmd_bus.slot         = '0;
    cmd_bus.ago          = '0;
    cmd_bus.sample_in    = '0;
    cmd_bus.sample_valid = 1'b0;
    res_bus.ready        = 1'b0;
    stall_left           = 0;
    mismatch_cnt         = 0;
    quiet_cycles         = 0;
    idle_on              = 1'b1;
    ring_depth           = 1;
    empty_rings();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_depth_one();
    test_depth_growth();
    test_full_depth();

    wait_until_drained();
    if (mismatch_cnt == 0 && pending_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
